/* hw/rtl/multi_pattern_string_matcher_unit_defines.svh */
// Assertion macros shared by the matcher RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MULTI_PATTERN_STRING_MATCHER_UNIT_DEFINES_SVH
`define MULTI_PATTERN_STRING_MATCHER_UNIT_DEFINES_SVH

// plain property, checked at every clock edge outside reset
`define MPSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define MPSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  `MPSM_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define MPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MPSM_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* hw/rtl/mpsm_pkg.sv */
// Package for the multi-pattern string matcher: sizes, word types, codes.
// No dependencies.
`timescale 1ns / 1ps

package mpsm_pkg;

  localparam int MaxNodes    = 1024;
  localparam int Alphabet    = 26;
  localparam int MaxPatterns = 256;
  localparam int CountWidth  = 32;

  localparam int NodeW = $clog2(MaxNodes);
  localparam int TotW  = NodeW + 1;
  localparam int LetW  = 5;
  localparam int IdW   = 8;
  localparam int SlotW = $clog2(MaxNodes * Alphabet);

  localparam logic [CountWidth-1:0] CntMax = {CountWidth{1'b1}};

  typedef logic [NodeW-1:0] node_t;
  typedef logic [SlotW-1:0] slot_t;

  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_LETTER = 3'd1,
    KIND_END    = 3'd2,
    KIND_BUILD  = 3'd3,
    KIND_TEXT   = 3'd4,
    KIND_READ   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_PHASE = 2'd2,
    ST_ID    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_RST_CLR,
    S_ROOT_CLR,
    S_IDLE,
    S_INS_RD,
    S_INS_CLR,
    S_TXT_RD,
    S_TXT_WALK,
    S_RD_MAP,
    S_RD_HIT,
    S_B_POP,
    S_B_U,
    S_B_FAIL,
    S_B_RD,
    S_B_EDGE,
    S_B_LINK,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [LetW-1:0]   letter;
    logic [IdW-1:0]    pattern_id;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  node;
    logic [31:0] count;
  } out_t;

  typedef struct packed {
    node_t fail;
    node_t outl;
  } link_t;

  typedef struct packed {
    logic                  term;
    logic [CountWidth-1:0] cnt;
  } hit_t;

  function automatic slot_t slot_addr(node_t n, logic [LetW-1:0] l);
    return slot_t'(n * Alphabet) + slot_t'(l);
  endfunction

endpackage

/* hw/rtl/mpsm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mpsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/multi_pattern_string_matcher_unit.sv */
// Aho-Corasick matcher over lowercase letters: trie insert, link build, text scan, count read.
// Uses mpsm_pkg, mpsm_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "multi_pattern_string_matcher_unit_defines.svh"

// One word in, one word out, one word at a time. After reset the root row of the goto
// store is cleared before the first word is taken; a clear word does the same. Each
// word ends by handing its result to the output register. A pattern letter that creates
// a node also zeroes its goto row one entry a cycle; a text letter bumps the counter of
// each terminal node on the output-link chain, one node per cycle. Build walks the trie
// breadth first: per node it pops the queue and reads the node and its fail link, per
// letter slot it reads the goto entries of the node and its fail node, and per child edge
// it writes the links; each step waits on the registered reads of the memories.
module multi_pattern_string_matcher_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mpsm_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mpsm_pkg::out_t out_word_o
);
  import mpsm_pkg::*;

  state_e state_q, state_d;
  in_t    in_q, in_d;
  out_t   res_q, res_d;
  out_t   out_q, out_d;
  logic   out_valid_q, out_valid_d;

  logic [TotW-1:0]        total_q, total_d;
  node_t                  ic_q, ic_d, mc_q, mc_d;
  logic                   built_q, built_d;
  logic [MaxPatterns-1:0] pvalid_q, pvalid_d;
  logic [TotW-1:0]        head_q, head_d, tail_q, tail_d;
  node_t                  u_q, u_d, fu_q, fu_d, v_q, v_d, f_q, f_d;
  logic [LetW-1:0]        c_q, c_d;

  // memory ports
  logic     g_we;
  slot_t    g_wa, g_ra0, g_ra1;
  node_t    g_wd, g_rd0, g_rd1;
  logic     l_we;
  node_t    l_wa, l_ra;
  link_t    l_wd, l_rd;
  logic     h_we;
  node_t    h_wa, h_ra;
  hit_t     h_wd, h_rd;
  logic     m_we;
  logic [IdW-1:0] m_wa, m_ra;
  node_t    m_wd, m_rd;
  logic     q_we;
  node_t    q_wa, q_ra, q_wd, q_rd;

  // goto store is mirrored so that a node row and its fail row read together
  mpsm_ram #(.Width(NodeW), .Depth(MaxNodes * Alphabet)) u_goto_a (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd), .raddr_i(g_ra0), .rdata_o(g_rd0)
  );
  mpsm_ram #(.Width(NodeW), .Depth(MaxNodes * Alphabet)) u_goto_b (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd), .raddr_i(g_ra1), .rdata_o(g_rd1)
  );
  mpsm_ram #(.Width($bits(link_t)), .Depth(MaxNodes)) u_link (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd), .raddr_i(l_ra), .rdata_o(l_rd)
  );
  mpsm_ram #(.Width($bits(hit_t)), .Depth(MaxNodes)) u_hit (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd)
  );
  mpsm_ram #(.Width(NodeW), .Depth(MaxPatterns)) u_map (
    .clk_i, .we_i(m_we), .waddr_i(m_wa), .wdata_i(m_wd), .raddr_i(m_ra), .rdata_o(m_rd)
  );
  mpsm_ram #(.Width(NodeW), .Depth(MaxNodes)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(q_ra), .rdata_o(q_rd)
  );

  logic  letter_bad, last_c, out_free, store_full;
  node_t edge_f;

  assign letter_bad = in_word_i.letter >= LetW'(Alphabet);
  assign last_c     = c_q == LetW'(Alphabet - 1);
  assign out_free   = !out_valid_q || out_ready_i;
  assign store_full = total_q >= TotW'(MaxNodes);
  assign edge_f     = (u_q == '0) ? '0 : g_rd1;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_RST_CLR:  if (last_c) state_d = S_IDLE;
      S_ROOT_CLR: if (last_c) state_d = S_DONE;
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_word_i.kind)
            KIND_CLEAR:  state_d = S_ROOT_CLR;
            KIND_LETTER: state_d = (built_q || letter_bad) ? S_DONE : S_INS_RD;
            KIND_END:    state_d = S_DONE;
            KIND_BUILD:  state_d = built_q ? S_DONE : S_B_POP;
            KIND_TEXT:   state_d = (!built_q || letter_bad) ? S_DONE : S_TXT_RD;
            KIND_READ:   state_d = pvalid_q[in_word_i.pattern_id] ? S_RD_MAP : S_DONE;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_INS_RD:   state_d = (g_rd0 != '0 || store_full) ? S_DONE : S_INS_CLR;
      S_INS_CLR:  if (last_c) state_d = S_DONE;
      S_TXT_RD:   state_d = (g_rd0 == '0) ? S_DONE : S_TXT_WALK;
      S_TXT_WALK: if (l_rd.outl == '0) state_d = S_DONE;
      S_RD_MAP:   state_d = S_RD_HIT;
      S_RD_HIT:   state_d = S_DONE;
      S_B_POP:    state_d = (head_q == tail_q) ? S_DONE : S_B_U;
      S_B_U:      state_d = S_B_FAIL;
      S_B_FAIL:   state_d = S_B_RD;
      S_B_RD:     state_d = S_B_EDGE;
      S_B_EDGE: begin
        if (g_rd0 != '0) state_d = S_B_LINK;
        else state_d = last_c ? S_B_POP : S_B_RD;
      end
      S_B_LINK:   state_d = last_c ? S_B_POP : S_B_RD;
      S_DONE:     if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_d = in_q; res_d = res_q; out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    total_d = total_q; ic_d = ic_q; mc_d = mc_q; built_d = built_q; pvalid_d = pvalid_q;
    head_d = head_q; tail_d = tail_q; u_d = u_q; fu_d = fu_q; v_d = v_q; f_d = f_q;
    c_d = c_q;
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra0 = '0; g_ra1 = '0;
    l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
    h_we = 1'b0; h_wa = '0; h_wd = '0; h_ra = '0;
    m_we = 1'b0; m_wa = '0; m_wd = '0; m_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    case (state_q)
      S_RST_CLR, S_ROOT_CLR, S_INS_CLR: begin
        // zero one goto entry of row v per cycle
        g_we = 1'b1;
        g_wa = slot_addr(v_q, c_q);
        c_d  = c_q + 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          in_d  = in_word_i;
          res_d = '{status: ST_OK, node: '0, count: '0};
          case (in_word_i.kind)
            KIND_CLEAR: begin
              total_d = TotW'(1); ic_d = '0; mc_d = '0; built_d = 1'b0; pvalid_d = '0;
              v_d = '0; c_d = '0;
            end
            KIND_LETTER: begin
              if (built_q || letter_bad) begin
                res_d = '{status: ST_PHASE, node: 10'(ic_q), count: '0};
              end else begin
                g_ra0 = slot_addr(ic_q, in_word_i.letter);
              end
            end
            KIND_END: begin
              if (built_q) begin
                res_d.status = ST_PHASE;
              end else begin
                // counters stay zero until links are built
                if (ic_q != '0) begin
                  h_we = 1'b1; h_wa = ic_q; h_wd = '{term: 1'b1, cnt: '0};
                end
                m_we = 1'b1; m_wa = in_word_i.pattern_id; m_wd = ic_q;
                pvalid_d[in_word_i.pattern_id] = 1'b1;
                ic_d = '0;
                res_d.node = 10'(ic_q);
              end
            end
            KIND_BUILD: begin
              if (built_q) begin
                res_d.status = ST_PHASE;
              end else begin
                l_we = 1'b1; l_wa = '0; l_wd = '0;
                q_we = 1'b1; q_wa = '0; q_wd = '0;
                head_d = '0; tail_d = TotW'(1);
              end
            end
            KIND_TEXT: begin
              if (!built_q || letter_bad) begin
                res_d = '{status: ST_PHASE, node: 10'(mc_q), count: '0};
              end else begin
                g_ra0 = slot_addr(mc_q, in_word_i.letter);
              end
            end
            KIND_READ: begin
              if (pvalid_q[in_word_i.pattern_id]) m_ra = in_word_i.pattern_id;
              else res_d.status = ST_ID;
            end
            default: res_d.status = ST_PHASE;
          endcase
        end
      end
      S_INS_RD: begin
        if (g_rd0 != '0) begin
          ic_d = g_rd0;
          res_d = '{status: ST_OK, node: 10'(g_rd0), count: '0};
        end else if (store_full) begin
          res_d = '{status: ST_FULL, node: 10'(ic_q), count: '0};
        end else begin
          g_we = 1'b1; g_wa = slot_addr(ic_q, in_q.letter); g_wd = total_q[NodeW-1:0];
          h_we = 1'b1; h_wa = total_q[NodeW-1:0]; h_wd = '0;
          total_d = total_q + 1'b1;
          ic_d = total_q[NodeW-1:0];
          v_d  = total_q[NodeW-1:0];
          c_d  = '0;
          res_d = '{status: ST_OK, node: 10'(total_q[NodeW-1:0]), count: '0};
        end
      end
      S_TXT_RD: begin
        mc_d = g_rd0;
        res_d = '{status: ST_OK, node: 10'(g_rd0), count: '0};
        v_d = g_rd0; h_ra = g_rd0; l_ra = g_rd0;
      end
      S_TXT_WALK: begin
        // bump node v, fetch the next node on the output chain
        if (h_rd.term && h_rd.cnt != CntMax) begin
          h_we = 1'b1; h_wa = v_q; h_wd = '{term: 1'b1, cnt: h_rd.cnt + 1'b1};
        end
        v_d = l_rd.outl; h_ra = l_rd.outl; l_ra = l_rd.outl;
      end
      S_RD_MAP: begin
        v_d = m_rd; h_ra = m_rd;
      end
      S_RD_HIT: begin
        // root entry is never written; an empty pattern reads zero
        res_d = '{status: ST_OK, node: 10'(v_q),
                  count: (v_q == '0) ? '0 : 32'(h_rd.cnt)};
      end
      S_B_POP: begin
        if (head_q == tail_q) begin
          built_d = 1'b1; ic_d = '0; mc_d = '0;
        end else begin
          q_ra = head_q[NodeW-1:0];
          head_d = head_q + 1'b1;
        end
      end
      S_B_U: begin
        u_d = q_rd; l_ra = q_rd;
      end
      S_B_FAIL: begin
        fu_d = l_rd.fail; c_d = '0;
      end
      S_B_RD: begin
        g_ra0 = slot_addr(u_q, c_q);
        g_ra1 = slot_addr(fu_q, c_q);
      end
      S_B_EDGE: begin
        if (g_rd0 == '0) begin
          g_we = 1'b1; g_wa = slot_addr(u_q, c_q); g_wd = edge_f;
          c_d = c_q + 1'b1;
        end else begin
          v_d = g_rd0; f_d = edge_f; l_ra = edge_f; h_ra = edge_f;
        end
      end
      S_B_LINK: begin
        l_we = 1'b1; l_wa = v_q;
        l_wd = '{fail: f_q, outl: (f_q != '0 && h_rd.term) ? f_q : l_rd.outl};
        if (tail_q < TotW'(MaxNodes)) begin
          q_we = 1'b1; q_wa = tail_q[NodeW-1:0]; q_wd = v_q;
          tail_d = tail_q + 1'b1;
        end
        c_d = c_q + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_d = res_q; out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RST_CLR;
      out_valid_q <= 1'b0;
      total_q     <= TotW'(1);
      ic_q        <= '0;
      mc_q        <= '0;
      built_q     <= 1'b0;
      pvalid_q    <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      v_q         <= '0;
      c_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      ic_q        <= ic_d;
      mc_q        <= mc_d;
      built_q     <= built_d;
      pvalid_q    <= pvalid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      v_q         <= v_d;
      c_q         <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
    out_q <= out_d;
    u_q   <= u_d;
    fu_q  <= fu_d;
    f_q   <= f_d;
  end

  `MPSM_ASSERT(a_total_range, (total_q != '0) && (total_q <= TotW'(MaxNodes)),
               "node total out of range")
  `MPSM_ASSERT(a_icur_range, {1'b0, ic_q} < total_q, "insert cursor beyond node total")
  `MPSM_ASSERT(a_mcur_range, {1'b0, mc_q} < total_q, "match state beyond node total")
  `MPSM_ASSERT_IMPL(a_queue_order,
                    state_q == S_B_POP || state_q == S_B_RD || state_q == S_B_EDGE,
                    head_q <= tail_q, "walk queue head passed tail")
  `MPSM_ASSERT_NEXT(a_done_hold, state_q == S_DONE && out_valid_q && !out_ready_i,
                    state_q == S_DONE, "result dropped while output word stalled")

endmodule

/* bench/testbench.sv */
// Testbench for multi_pattern_string_matcher_unit: random and directed words, scoreboard check.
// Depends on mpsm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module testbench;
  import mpsm_pkg::*;

  localparam int WatchLimit = 200000;

  // Behavioral copy of the matcher; predicts one result word per input word.
  class match_scoreboard;
    logic [9:0]  gt [MaxNodes*Alphabet];
    logic [9:0]  fl [MaxNodes];
    logic [9:0]  ol [MaxNodes];
    bit          term [MaxNodes];
    logic [31:0] hits [MaxNodes];
    logic [9:0]  pmap [MaxPatterns];
    bit          pval [MaxPatterns];
    int          total;
    logic [9:0]  icur, mcur;
    bit          built;
    out_t        pending [$];
    int          errors;
    int          checked;

    function void clear_all();
      foreach (gt[i]) gt[i] = '0;
      foreach (fl[i]) begin
        fl[i] = '0; ol[i] = '0; term[i] = 0; hits[i] = '0;
      end
      foreach (pmap[i]) begin
        pmap[i] = '0; pval[i] = 0;
      end
      total = 1; icur = '0; mcur = '0; built = 0;
    endfunction

    function void build_links();
      int q [$];
      int u, v, f;
      fl[0] = '0; ol[0] = '0;
      q.push_back(0);
      while (q.size() > 0) begin
        u = q.pop_front();
        for (int c = 0; c < Alphabet; c++) begin
          v = gt[u*Alphabet+c];
          if (v == 0) begin
            gt[u*Alphabet+c] = (u == 0) ? 10'd0 : gt[fl[u]*Alphabet+c];
          end else begin
            f = (u == 0) ? 0 : gt[fl[u]*Alphabet+c];
            fl[v] = f;
            ol[v] = term[f] ? 10'(f) : ol[f];
            q.push_back(v);
          end
        end
      end
    endfunction

    function void note_word(in_t w);
      out_t r;
      int v, x;
      r = '{status: ST_OK, node: '0, count: '0};
      case (w.kind)
        KIND_CLEAR: clear_all();
        KIND_LETTER: begin
          if (built || w.letter >= Alphabet) begin
            r.status = ST_PHASE; r.node = icur;
          end else begin
            v = gt[icur*Alphabet+w.letter];
            if (v == 0 && total >= MaxNodes) begin
              r.status = ST_FULL; r.node = icur;
            end else begin
              if (v == 0) begin
                v = total++;
                for (int c = 0; c < Alphabet; c++) gt[v*Alphabet+c] = '0;
                fl[v] = '0; ol[v] = '0; term[v] = 0; hits[v] = '0;
                gt[icur*Alphabet+w.letter] = 10'(v);
              end
              icur = 10'(v); r.node = icur;
            end
          end
        end
        KIND_END: begin
          if (built) r.status = ST_PHASE;
          else begin
            if (icur != 0) term[icur] = 1;
            pmap[w.pattern_id] = icur; pval[w.pattern_id] = 1;
            r.node = icur; icur = '0;
          end
        end
        KIND_BUILD: begin
          if (built) r.status = ST_PHASE;
          else begin
            build_links(); built = 1; icur = '0; mcur = '0;
          end
        end
        KIND_TEXT: begin
          if (!built || w.letter >= Alphabet) begin
            r.status = ST_PHASE; r.node = mcur;
          end else begin
            mcur = gt[mcur*Alphabet+w.letter];
            x = mcur;
            for (int g = 0; x != 0 && g < MaxNodes; g++) begin
              if (term[x] && hits[x] != CntMax) hits[x]++;
              x = ol[x];
            end
            r.node = mcur;
          end
        end
        KIND_READ: begin
          if (!pval[w.pattern_id]) r.status = ST_ID;
          else begin
            r.node = pmap[w.pattern_id]; r.count = hits[r.node];
          end
        end
        default: r.status = ST_PHASE;
      endcase
      pending.push_back(r);
    endfunction

    function void check_word(out_t got);
      out_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status); errors++;
      end
      if (got.node !== e.node) begin
        $error("node: expected %0d, actual %0d", e.node, got.node); errors++;
      end
      if (got.count !== e.count) begin
        $error("count: expected %0d, actual %0d", e.count, got.count); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  in_t  in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  out_t out_word_o;

  match_scoreboard sb;
  bit   calm = 0;       // no idling near the end
  bit   hold_rx = 0;    // long receiver hold-off
  int   idle_cnt = 0;
  int   sent = 0;

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  multi_pattern_string_matcher_unit i_dut (.*);

  always @(posedge clk_i)
    if (in_valid_i && in_ready_o) sb.note_word(in_word_i);

  always @(posedge clk_i)
    if (out_valid_o && out_ready_i) sb.check_word(out_word_o);

  // receiver: random stall bursts, one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_ready_i <= 0;
        for (n = 0; n < 400; n++) @(posedge clk_i);
        hold_rx = 0;
        out_ready_i <= 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        n = $urandom_range(1, 4);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WatchLimit) begin
      $display("watchdog: no handshake for %0d cycles", WatchLimit);
      $display("** multi_pattern_string_matcher_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_word(input logic [2:0] k, input logic [4:0] l, input logic [7:0] id);
    in_t w;
    int g;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      g = $urandom_range(1, 4);
      repeat (g) @(posedge clk_i);
    end
    w.kind = kind_e'(k); w.letter = l; w.pattern_id = id;
    in_valid_i <= 1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic end_stream();
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // add one pattern of random letters from 0 up to span
  task automatic add_pattern(input int len, input int span, input logic [7:0] id);
    for (int i = 0; i < len; i++) send_word(KIND_LETTER, 5'($urandom_range(0, span)), id);
    send_word(KIND_END, 5'($urandom), id);
  endtask

  task automatic random_session(input int npat, input int ntext, input int span);
    send_word(KIND_CLEAR, 5'($urandom), 8'($urandom));
    for (int p = 0; p < npat; p++) begin
      if ($urandom_range(0, 9) == 0)
        send_word(3'($urandom), 5'($urandom), 8'($urandom));   // noise
      add_pattern($urandom_range(0, 4), span, 8'($urandom_range(0, 15)));
    end
    send_word(KIND_BUILD, 5'($urandom), 8'($urandom));
    for (int t = 0; t < ntext; t++) begin
      case ($urandom_range(0, 9))
        0: send_word(KIND_READ, 5'($urandom), 8'($urandom_range(0, 15)));
        1: send_word(3'($urandom), 5'($urandom), 8'($urandom));
        default: send_word(KIND_TEXT, 5'($urandom_range(0, span)), 8'($urandom));
      endcase
    end
    for (int r = 0; r < 16; r++) send_word(KIND_READ, 5'($urandom), 8'(r));
  endtask

  initial begin
    int wait_n;
    sb = new();
    sb.clear_all();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: unknown ids, phase errors, empty pattern, extremes
    send_word(KIND_READ, 5'd0, 8'd255);
    send_word(KIND_TEXT, 5'd0, 8'd0);
    send_word(KIND_LETTER, 5'd31, 8'd0);
    send_word(KIND_END, 5'd0, 8'd7);            // empty pattern
    send_word(KIND_LETTER, 5'd25, 8'd0);
    send_word(KIND_LETTER, 5'd0, 8'd0);
    send_word(KIND_END, 5'd0, 8'd255);
    send_word(KIND_LETTER, 5'd0, 8'd0);
    send_word(KIND_END, 5'd0, 8'd1);
    send_word(KIND_LETTER, 5'd0, 8'd0);
    send_word(KIND_END, 5'd0, 8'd1);            // id ended twice
    send_word(KIND_LETTER, 5'd3, 8'd0);         // unfinished at build
    send_word(KIND_BUILD, 5'd0, 8'd0);
    send_word(KIND_BUILD, 5'd0, 8'd0);
    send_word(KIND_LETTER, 5'd1, 8'd0);
    send_word(KIND_END, 5'd0, 8'd2);
    send_word(KIND_TEXT, 5'd25, 8'd0);
    send_word(KIND_TEXT, 5'd0, 8'd0);
    send_word(KIND_TEXT, 5'd0, 8'd0);
    send_word(KIND_TEXT, 5'd26, 8'd0);
    send_word(3'd6, 5'd0, 8'd0);
    send_word(3'd7, 5'd31, 8'd255);
    send_word(KIND_READ, 5'd0, 8'd1);
    send_word(KIND_READ, 5'd0, 8'd7);
    send_word(KIND_READ, 5'd0, 8'd255);

    // receiver hold-off while the sender keeps offering
    hold_rx = 1;
    random_session(6, 40, 2);

    while (sent < 650) random_session($urandom_range(2, 8), $urandom_range(20, 80),
                                      $urandom_range(1, 3) == 1 ? 25 : 2);
    calm = 1;
    random_session(5, 40, 2);
    end_stream();

    wait_n = 0;
    while (sb.pending.size() > 0 && wait_n < WatchLimit) begin
      @(posedge clk_i);
      wait_n++;
    end
    repeat (100) @(posedge clk_i);
    $display("covered %0d input words, %0d results checked: insert, build, scan, reads,",
             sent, sb.checked);
    $display("phase and id errors, empty patterns, output stalls");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** multi_pattern_string_matcher_unit: PASSED **");
    end else begin
      $display("** multi_pattern_string_matcher_unit: FAILED **");
    end
    $finish;
  end
endmodule
